[rtl/core/rcfe_pkg.sv]
`timescale 1ns / 1ps

package rcfe_pkg;

    localparam int unsigned CH_W       = 11;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned MAX_BURST  = 4;
    localparam int unsigned BURST_CNT_W = 3;
    localparam int unsigned CHAN_IDX_W = 4;
    localparam int unsigned PEND_W     = 7;
    localparam int unsigned PEND_CNT_W = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0]     HDR_LEN_BYTE  = 8'd24;
    localparam logic [BYTE_W-1:0]     HDR_TYPE      = 8'h16;
    localparam logic [BYTE_W-1:0]     CRC_POLY      = 8'h8C;
    localparam logic [BYTE_W-1:0]     DEST_RESET    = 8'hC8;
    localparam logic [CH_W-1:0]       INV_BASE      = 11'd1983;
    localparam logic [CHAN_IDX_W-1:0] FIRST_CHANNEL = 4'd0;
    localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL  = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDRESS = 8'd1;

    // up to four frame bytes produced by one channel word
    typedef struct packed {
        logic [MAX_BURST-1:0][BYTE_W-1:0] data;
        logic [BURST_CNT_W-1:0]           count;
        logic                             has_end;
    } burst_t;

    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] din);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] b;
        logic              mix;
        c = crc;
        b = din;
        for (int i = 0; i < BYTE_W; i++) begin
            mix = c[0] ^ b[0];
            c   = c >> 1;
            if (mix) begin
                c = c ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return c;
    endfunction

endpackage

[rtl/core/rcfe_cfg.sv]
`timescale 1ns / 1ps

module rcfe_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [15:0]                    invert_mask,
    output logic [rcfe_pkg::BYTE_W-1:0]     dest_address
);

    logic [15:0]                invert_mask_reg;
    logic [rcfe_pkg::BYTE_W-1:0] dest_address_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_mask_reg  <= '0;
            dest_address_reg <= rcfe_pkg::DEST_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rcfe_pkg::CFG_INVERT_MASK: begin
                    invert_mask_reg <= cfg_data;
                end
                rcfe_pkg::CFG_DEST_ADDRESS: begin
                    dest_address_reg <= cfg_data[rcfe_pkg::BYTE_W-1:0];
                end
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    assign invert_mask  = invert_mask_reg;
    assign dest_address = dest_address_reg;

endmodule

[rtl/core/rcfe_pack.sv]
`timescale 1ns / 1ps

module rcfe_pack (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rcfe_pkg::CH_W-1:0]   s_channel_value,
    input  logic [15:0]                 invert_mask,
    input  logic [rcfe_pkg::BYTE_W-1:0] dest_address,
    output logic                        burst_valid,
    input  logic                        burst_ready,
    output rcfe_pkg::burst_t            burst
);

    logic                                in_valid_reg;
    logic [rcfe_pkg::CH_W-1:0]           in_value_reg;
    logic [rcfe_pkg::CHAN_IDX_W-1:0]     channel_count_reg;
    logic [rcfe_pkg::PEND_W-1:0]         pending_bits_reg;
    logic [rcfe_pkg::PEND_CNT_W-1:0]     pending_count_reg;
    logic [rcfe_pkg::BYTE_W-1:0]         crc_reg;

    logic                                advance;
    logic                                first_ch;
    logic                                last_ch;
    logic [rcfe_pkg::CH_W-1:0]           value_mapped;
    logic [rcfe_pkg::PEND_W-1:0]         pend_bits;
    logic [rcfe_pkg::PEND_CNT_W-1:0]     pend_cnt;
    logic [17:0]                         acc;
    logic [4:0]                          bit_cnt;
    logic                                two_bytes;
    logic [rcfe_pkg::BYTE_W-1:0]         byte0;
    logic [rcfe_pkg::BYTE_W-1:0]         byte1;
    logic [rcfe_pkg::BYTE_W-1:0]         crc_start;
    logic [rcfe_pkg::BYTE_W-1:0]         crc_a;
    logic [rcfe_pkg::BYTE_W-1:0]         crc_b;
    logic [rcfe_pkg::CHAN_IDX_W-1:0]     channel_count_next;
    logic [rcfe_pkg::PEND_W-1:0]         pending_bits_next;
    logic [rcfe_pkg::PEND_CNT_W-1:0]     pending_count_next;

    assign advance = in_valid_reg && burst_ready;
    assign s_ready = !in_valid_reg || burst_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_channel_value;
        end
    end

    assign first_ch = (channel_count_reg == rcfe_pkg::FIRST_CHANNEL);
    assign last_ch  = (channel_count_reg == rcfe_pkg::LAST_CHANNEL);

    // mirrored value wraps within 11 bits
    assign value_mapped = invert_mask[channel_count_reg] ?
                          (rcfe_pkg::INV_BASE - in_value_reg) : in_value_reg;

    // a frame starts with nothing pending
    assign pend_bits = first_ch ? '0 : pending_bits_reg;
    assign pend_cnt  = first_ch ? '0 : pending_count_reg;

    assign acc       = ({7'd0, value_mapped} << pend_cnt) | {11'd0, pend_bits};
    assign bit_cnt   = {2'd0, pend_cnt} + 5'd11;
    assign two_bytes = bit_cnt[4];
    assign byte0     = acc[7:0];
    assign byte1     = acc[15:8];

    assign crc_start = first_ch ? rcfe_pkg::crc8_byte(8'h00, rcfe_pkg::HDR_TYPE) : crc_reg;
    assign crc_a     = rcfe_pkg::crc8_byte(crc_start, byte0);
    assign crc_b     = two_bytes ? rcfe_pkg::crc8_byte(crc_a, byte1) : crc_a;

    assign channel_count_next = channel_count_reg + 4'd1;
    assign pending_bits_next  = last_ch ? '0 :
                                (two_bytes ? {5'd0, acc[17:16]} : acc[14:8]);
    assign pending_count_next = last_ch ? '0 : bit_cnt[2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channel_count_reg <= '0;
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            crc_reg           <= '0;
        end else if (advance) begin
            channel_count_reg <= channel_count_next;
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            crc_reg           <= crc_b;
        end
    end

    always_comb begin
        burst         = '0;
        burst.has_end = last_ch;
        if (first_ch) begin
            burst.data[0] = dest_address;
            burst.data[1] = rcfe_pkg::HDR_LEN_BYTE;
            burst.data[2] = rcfe_pkg::HDR_TYPE;
            burst.data[3] = byte0;
            burst.count   = 3'd4;
        end else if (last_ch) begin
            // CRC follows the payload bytes
            burst.data[0] = byte0;
            burst.data[1] = two_bytes ? byte1 : crc_b;
            burst.data[2] = crc_b;
            burst.count   = two_bytes ? 3'd3 : 3'd2;
        end else begin
            burst.data[0] = byte0;
            burst.data[1] = byte1;
            burst.count   = two_bytes ? 3'd2 : 3'd1;
        end
    end

    assign burst_valid = in_valid_reg;

endmodule

[rtl/core/rcfe_ser.sv]
`timescale 1ns / 1ps

module rcfe_ser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        burst_valid,
    output logic                        burst_ready,
    input  rcfe_pkg::burst_t            burst,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rcfe_pkg::BYTE_W-1:0] m_frame_byte,
    output logic                        m_frame_end
);

    rcfe_pkg::burst_t burst_reg;
    logic             valid_reg;
    logic [1:0]       idx_reg;
    logic             last_byte;

    assign last_byte   = ({1'b0, idx_reg} + 3'd1) == burst_reg.count;
    assign burst_ready = !valid_reg || (m_ready && last_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (burst_ready) begin
            valid_reg <= burst_valid;
            idx_reg   <= '0;
        end else if (m_ready) begin
            // advance to the next byte of the held burst
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (burst_ready && burst_valid) begin
            burst_reg <= burst;
        end
    end

    assign m_valid      = valid_reg;
    assign m_frame_byte = burst_reg.data[idx_reg];
    assign m_frame_end  = burst_reg.has_end && last_byte;

endmodule

[rtl/core/rc_channel_frame_encoder.sv]
`timescale 1ns / 1ps

// Latency: a taken word is held in the rcfe_pack input register, then in rcfe_ser.
// Throughput: one frame byte per cycle while m_ready is high; a word yields 1 to 4 frame
// bytes (its byte count), 26 bytes per 16-channel frame.
// Reset: aresetn (synchronous, active low) empties the pipeline, restarts at channel 0,
// clears the CRC and pending bits, and sets invert_mask to 0 and dest_address to 0xC8.
module rc_channel_frame_encoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [rcfe_pkg::CH_W-1:0]       s_channel_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [rcfe_pkg::BYTE_W-1:0]     m_frame_byte,
    output logic                           m_frame_end,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [15:0]                 invert_mask;
    logic [rcfe_pkg::BYTE_W-1:0] dest_address;
    logic                        burst_valid;
    logic                        burst_ready;
    rcfe_pkg::burst_t            burst;

    rcfe_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .invert_mask  (invert_mask),
        .dest_address (dest_address)
    );

    rcfe_pack u_pack (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .invert_mask     (invert_mask),
        .dest_address    (dest_address),
        .burst_valid     (burst_valid),
        .burst_ready     (burst_ready),
        .burst           (burst)
    );

    rcfe_ser u_ser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .burst_valid  (burst_valid),
        .burst_ready  (burst_ready),
        .burst        (burst),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_frame_end  (m_frame_end)
    );

endmodule

[tb/rc_frame_checker.sv]
`timescale 1ns / 1ps

module rc_frame_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [rcfe_pkg::CH_W-1:0]       s_channel_value,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [rcfe_pkg::BYTE_W-1:0]     m_frame_byte,
    input  logic                            m_frame_end,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rcfe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcfe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              error_count,
    output int                              bytes_due
);

    import rcfe_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_word_t;

    frame_word_t              frame_bytes_due[$];
    frame_word_t              want;

    logic [15:0]              inv_mask;
    logic [BYTE_W-1:0]        dest_addr;
    logic [CHAN_IDX_W-1:0]    chan_idx;
    logic [PEND_W-1:0]        carry_bits;
    logic [PEND_CNT_W-1:0]    carry_cnt;
    logic [BYTE_W-1:0]        crc_acc;
    int                       errors = 0;

    initial begin
        error_count = 0;
        bytes_due   = 0;
    end

    function automatic logic [BYTE_W-1:0] crc_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function void queue_byte(input logic [BYTE_W-1:0] data, input logic last);
        frame_word_t w;
        w.data = data;
        w.last = last;
        frame_bytes_due.push_back(w);
    endfunction

    // Append the frame bytes that one channel word produces.
    task encode_channel(input logic [CH_W-1:0] raw);
        logic [CH_W-1:0]   v;
        logic [17:0]       acc;
        int                nbits;
        logic [BYTE_W-1:0] b;
        if (chan_idx == FIRST_CHANNEL) begin
            queue_byte(dest_addr, 1'b0);
            queue_byte(HDR_LEN_BYTE, 1'b0);
            queue_byte(HDR_TYPE, 1'b0);
            crc_acc    = crc_update('0, HDR_TYPE);
            carry_bits = '0;
            carry_cnt  = '0;
        end
        v = raw;
        if (inv_mask[chan_idx]) begin
            v = INV_BASE - raw;   // wraps in 11 bits
        end
        acc   = (18'(v) << carry_cnt) | 18'(carry_bits);
        nbits = int'(carry_cnt) + CH_W;
        while (nbits >= BYTE_W) begin
            b = acc[BYTE_W-1:0];
            queue_byte(b, 1'b0);
            crc_acc = crc_update(crc_acc, b);
            acc     = acc >> BYTE_W;
            nbits   = nbits - BYTE_W;
        end
        carry_bits = acc[PEND_W-1:0];
        carry_cnt  = nbits[PEND_CNT_W-1:0];
        if (chan_idx == LAST_CHANNEL) begin
            queue_byte(crc_acc, 1'b1);
            carry_bits = '0;
            carry_cnt  = '0;
        end
        chan_idx = chan_idx + 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            inv_mask   = '0;
            dest_addr  = DEST_RESET;
            chan_idx   = FIRST_CHANNEL;
            carry_bits = '0;
            carry_cnt  = '0;
            crc_acc    = '0;
            frame_bytes_due.delete();
            bytes_due <= 0;
        end else begin
            // check outgoing word before predicting the incoming one
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected frame byte %02h end %0b",
                                 $realtime, m_frame_byte, m_frame_end);
                    end
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (want.data !== m_frame_byte || want.last !== m_frame_end) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: frame byte mismatch: expected %02h end %0b, got %02h end %0b",
                                     $realtime, want.data, want.last, m_frame_byte,
                                     m_frame_end);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INVERT_MASK: begin
                        inv_mask = cfg_data[15:0];
                    end
                    CFG_DEST_ADDRESS: begin
                        dest_addr = cfg_data[BYTE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                encode_channel(s_channel_value);
            end
            error_count <= errors;
            bytes_due   <= frame_bytes_due.size();
        end
    end

endmodule

[tb/rc_channel_frame_encoder_test.sv]
`timescale 1ns / 1ps

module rc_channel_frame_encoder_test;

    import rcfe_pkg::*;

    localparam int                   HOLD_CYCLES    = 300;
    localparam int                   DRAIN_CYCLES   = 12;
    localparam int                   PHASE_WORDS    = 87;
    localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX  = 8'hFF;

    // extremes and bit patterns for the first frame
    localparam logic [15:0][CH_W-1:0] EDGE_FRAME = {
        11'd0, 11'd2047, 11'd1983, 11'd1984, 11'd1, 11'd2046, 11'h555, 11'h2AA,
        11'd1024, 11'd1023, 11'd0, 11'd2047, 11'd0, 11'd2047, 11'd7, 11'd1983
    };
    localparam logic [7:0][CH_W-1:0] MIRROR_WORDS = {
        11'd2047, 11'd1984, 11'd1983, 11'd0, 11'd1, 11'd1982, 11'd1024, 11'd2047
    };

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

    logic                    aclk            = 1'b0;
    logic                    aresetn         = 1'b0;
    logic                    s_valid         = 1'b0;
    logic                    s_ready;
    logic [CH_W-1:0]         s_channel_value = '0;
    logic                    m_valid;
    logic                    m_ready         = 1'b0;
    logic [BYTE_W-1:0]       m_frame_byte;
    logic                    m_frame_end;
    logic                    cfg_valid       = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index       = '0;
    logic [CFG_DATA_W-1:0]   cfg_data        = '0;

    int                      error_count;
    int                      bytes_due;
    int                      burst_left      = 0;
    logic                    hold_go         = 1'b0;
    logic                    rx_hold         = 1'b0;
    rx_mode_t                rx_mode         = RX_OPEN;
    int                      rx_left         = 20;

    rc_channel_frame_encoder u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_frame_end     (m_frame_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    rc_frame_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_channel_value (s_channel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_byte    (m_frame_byte),
        .m_frame_end     (m_frame_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .bytes_due       (bytes_due)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stall pattern, overridden by the long hold-off
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(8, 80);
        end else begin
            rx_left--;
        end
        if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= ($urandom_range(0, 1) == 1);
                RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // hold the result channel off so the encoder backs up into its input
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold = 1'b0;
    end

    function automatic logic [CH_W-1:0] pick_value();
        logic [CH_W-1:0] v;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 5))
                0:       v = 11'd0;
                1:       v = 11'd2047;
                2:       v = 11'd1983;
                3:       v = 11'd1984;
                4:       v = 11'd1;
                default: v = 11'd1982;
            endcase
        end else begin
            v = CH_W'($urandom_range(0, 2047));
        end
        return v;
    endfunction

    // Call at a falling edge; returns at a falling edge, valid possibly still high.
    task automatic offer_word(input logic [CH_W-1:0] v);
        s_channel_value <= v;
        s_valid         <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // drop valid, then wait for every outstanding frame byte
    task automatic drain_frames();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (bytes_due != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: plain channels, default destination
        for (int i = 0; i < 16; i++) begin
            offer_word(EDGE_FRAME[i]);
        end
        drain_frames();

        // mirror everything; upper data bits of the destination get dropped
        write_reg(CFG_INVERT_MASK, 16'hFFFF);
        write_reg(CFG_DEST_ADDRESS, 16'hFFFF);
        for (int i = 0; i < 8; i++) begin
            offer_word(MIRROR_WORDS[i]);
        end
        drain_frames();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_INVERT_MASK, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_reg(CFG_DEST_ADDRESS, CFG_DATA_W'($urandom_range(0, 65535)));
                end
                1: begin
                    write_reg(CFG_INVERT_MASK, 16'h0000);
                    write_reg(CFG_DEST_ADDRESS, 16'h0000);
                end
                2: begin
                    write_reg(CFG_INVERT_MASK, 16'hFFFF);
                    write_reg(CFG_DEST_ADDRESS, 16'h00FF);
                end
                default: begin
                    write_reg(CFG_INVERT_MASK, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_reg(CFG_DEST_ADDRESS, CFG_DATA_W'($urandom_range(0, 255)));
                    // unknown indexes must leave both registers alone
                    write_reg(CFG_BAD_INDEX, CFG_DATA_W'($urandom_range(0, 65535)));
                    write_reg(CFG_TOP_INDEX, CFG_DATA_W'($urandom_range(0, 65535)));
                end
            endcase
            if (phase == 1) begin
                hold_go = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 2 && n == 40) begin
                    drain_frames();
                end
                offer_word(pick_value());
            end
            drain_frames();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && bytes_due == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rcfe_pkg.sv
rtl/core/rcfe_cfg.sv
rtl/core/rcfe_pack.sv
rtl/core/rcfe_ser.sv
rtl/core/rc_channel_frame_encoder.sv
tb/rc_frame_checker.sv
tb/rc_channel_frame_encoder_test.sv
